[src/pid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg
// Shared widths, limits and register codes for the clamped PID step.
// ----------------------------------------------------------------------------
package pid_pkg;

    // field and datapath widths
    localparam int unsigned ErrW   = 16;
    localparam int unsigned GainW  = 19;
    localparam int unsigned DriveW = 17;
    localparam int unsigned DerivW = ErrW + 1;
    localparam int unsigned ProdW  = GainW + 1 + DerivW;
    localparam int unsigned SumW   = ProdW + 2;
    localparam int unsigned Frac   = 16;
    localparam int unsigned ShW    = SumW - Frac;

    // apb port
    localparam int unsigned AddrW  = 4;
    localparam int unsigned DataW  = 32;

    // integral and output bounds
    localparam logic signed [DerivW-1:0] IntegMax  = 17'sd16384;
    localparam logic signed [DerivW-1:0] IntegMin  = -17'sd16384;
    localparam logic signed [ShW-1:0]    DriveMax  = 23'sd49152;
    localparam logic signed [ShW-1:0]    DriveMin  = -23'sd49152;

    // register indexes
    typedef enum logic [1:0] {
        REG_PROP  = 2'd0,
        REG_INTEG = 2'd1,
        REG_DERIV = 2'd2
    } t_reg_idx;

    typedef logic [GainW-1:0]         t_gain;
    typedef logic signed [ErrW-1:0]   t_err;
    typedef logic signed [ProdW-1:0]  t_prod;

endpackage

[src/pid_step_with_clamps.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_with_clamps
// PID step on a Q2.14 error sample with integral clamp and output saturation.
// ----------------------------------------------------------------------------
// One error item per cycle is taken and one drive item per cycle is given out
// while the output side is not stalled. Each item passes three register
// stages: the first stage updates the integral and derivative, the second
// forms the three gain products, the third sums, floor-shifts by 16 and
// saturates to +/-3.0. Throughput is set by the integral and last-error
// update, which is written on each accepted item. Gains are read by the
// product stage and are meant to be written only while no item is in
// flight. Registers sit at byte addresses 0, 4 and 8;
// address 12 reads zero and ignores writes.
module pid_step_with_clamps (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // error item channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [pid_pkg::ErrW-1:0]    i_error_sample,
    // drive item channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pid_pkg::DriveW-1:0]  o_drive,
    output logic                               o_saturated,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pid_pkg::AddrW-1:0]          paddr,
    input  logic [pid_pkg::DataW-1:0]          pwdata,
    output logic [pid_pkg::DataW-1:0]          prdata,
    output logic                               pready
);

    pid_pkg::t_gain r_prop_gain, r_integ_gain, r_deriv_gain;
    pid_pkg::t_reg_idx w_idx;

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3, w_accept;

    pid_pkg::t_err                       r_integral_sum, r_last_error;
    logic signed [pid_pkg::DerivW-1:0]   w_acc_raw, w_acc, w_deriv;

    pid_pkg::t_err                       r_err1, r_acc1;
    logic signed [pid_pkg::DerivW-1:0]   r_deriv1;

    pid_pkg::t_prod                      r_p_prod, r_i_prod, r_d_prod;
    logic signed [pid_pkg::SumW-1:0]     w_sum;
    logic signed [pid_pkg::ShW-1:0]      w_shifted;
    logic signed [pid_pkg::DriveW-1:0]   w_drive;
    logic                                w_sat;

    logic signed [pid_pkg::DriveW-1:0]   r_drive;
    logic                                r_sat;

    // register file
    assign pready = 1'b1;
    assign w_idx  = pid_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                pid_pkg::REG_PROP:  r_prop_gain  <= pwdata[pid_pkg::GainW-1:0];
                pid_pkg::REG_INTEG: r_integ_gain <= pwdata[pid_pkg::GainW-1:0];
                pid_pkg::REG_DERIV: r_deriv_gain <= pwdata[pid_pkg::GainW-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (w_idx)
            pid_pkg::REG_PROP:  prdata = pid_pkg::DataW'(r_prop_gain);
            pid_pkg::REG_INTEG: prdata = pid_pkg::DataW'(r_integ_gain);
            pid_pkg::REG_DERIV: prdata = pid_pkg::DataW'(r_deriv_gain);
            default:            prdata = '0;
        endcase
    end

    // pipeline advance, each stage moves when the next one has room
    assign w_en3      = !r_v3 || i_out_ready;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1;
    assign w_accept   = i_in_valid && w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_in_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // integral with inclusive clamp, derivative against previous sample
    always_comb begin
        w_acc_raw = pid_pkg::DerivW'(r_integral_sum) + pid_pkg::DerivW'(i_error_sample);
        if (w_acc_raw > pid_pkg::IntegMax) begin
            w_acc = pid_pkg::IntegMax;
        end else if (w_acc_raw < pid_pkg::IntegMin) begin
            w_acc = pid_pkg::IntegMin;
        end else begin
            w_acc = w_acc_raw;
        end
        w_deriv = pid_pkg::DerivW'(i_error_sample) - pid_pkg::DerivW'(r_last_error);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral_sum <= '0;
            r_last_error   <= '0;
        end else if (w_accept) begin
            r_integral_sum <= w_acc[pid_pkg::ErrW-1:0];
            r_last_error   <= i_error_sample;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err1   <= i_error_sample;
            r_acc1   <= w_acc[pid_pkg::ErrW-1:0];
            r_deriv1 <= w_deriv;
        end
    end

    // stage 2: gain products, Q30, operands sign-extended to product width
    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_p_prod <= pid_pkg::t_prod'($signed({1'b0, r_prop_gain}))
                      * pid_pkg::t_prod'(r_err1);
            r_i_prod <= pid_pkg::t_prod'($signed({1'b0, r_integ_gain}))
                      * pid_pkg::t_prod'(r_acc1);
            r_d_prod <= pid_pkg::t_prod'($signed({1'b0, r_deriv_gain}))
                      * pid_pkg::t_prod'(r_deriv1);
        end
    end

    // stage 3: sum, floor shift, saturate
    always_comb begin
        w_sum = pid_pkg::SumW'(r_p_prod) + pid_pkg::SumW'(r_i_prod)
              + pid_pkg::SumW'(r_d_prod);
        w_shifted = w_sum[pid_pkg::SumW-1:pid_pkg::Frac];
        if (w_shifted > pid_pkg::DriveMax) begin
            w_drive = pid_pkg::DriveMax[pid_pkg::DriveW-1:0];
            w_sat   = 1'b1;
        end else if (w_shifted < pid_pkg::DriveMin) begin
            w_drive = pid_pkg::DriveMin[pid_pkg::DriveW-1:0];
            w_sat   = 1'b1;
        end else begin
            w_drive = w_shifted[pid_pkg::DriveW-1:0];
            w_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r_drive <= w_drive;
            r_sat   <= w_sat;
        end
    end

    assign o_out_valid = r_v3;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

endmodule

[src/pid_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_chk
// Port-level checks for the clamped PID step, bound to the top level.
// ----------------------------------------------------------------------------
module pid_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [pid_pkg::DriveW-1:0]  o_drive,
    input  logic                               o_saturated,
    input  logic                               pready
);

    // no item shows right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_drive) && $stable(o_saturated))
        else $error("stalled item changed");

    // drive stays inside +/-3.0
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= 17'sd49152) && (o_drive >= -17'sd49152))
        else $error("drive out of range");

    // saturated flag only with drive on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_drive == 17'sd49152) || (o_drive == -17'sd49152))
        else $error("saturated flag without rail value");

    // config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind pid_step_with_clamps pid_chk u_pid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_drive     (o_drive),
    .o_saturated (o_saturated),
    .pready      (pready)
);
